// ===== rtl/srr_pkg.sv =====
`default_nettype none
package srr_pkg;

   // Fixed field widths of the packet and result words.
   localparam int SEQ_W     = 3;
   localparam int PAYLOAD_W = 64;

   // Result kind codes.
   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CHECK,
      BK_RDATA,
      BK_ACK
   } back_state_type;

   // One queued command: the reduced sequence number to acknowledge.
   typedef struct packed {
      logic [SEQ_W-1:0] seq;
   } queue_word_type;

   // Status the back end reports to the front end.
   typedef struct packed {
      logic idle;
   } back_status_type;

endpackage
`default_nettype wire

// ===== rtl/srr_ram.sv =====
`default_nettype none
module srr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/srr_queue.sv =====
`default_nettype none
module srr_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire srr_pkg::queue_word_type push_word,
   input  wire logic                   pop,
   output srr_pkg::queue_word_type     pop_word,
   output logic                        empty,
   output logic                        full
);
   localparam int DEPTH = 2;

   srr_pkg::queue_word_type entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   // Pushes are dropped when full, pops are ignored when empty.
   always_comb begin
      do_push   = push && (count_ff != 2'(DEPTH));
      do_pop    = pop && (count_ff != 2'd0);
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   // Pointer and count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign pop_word = entry_ff[rd_ptr_ff];
   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'(DEPTH));

endmodule
`default_nettype wire

// ===== rtl/srr_front.sv =====
`default_nettype none
module srr_front #(
   parameter int SEQ_SPACE = 8,
   parameter int WINDOW    = 4,
   localparam int BASE_W   = $clog2(SEQ_SPACE),
   localparam int HEAD_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [srr_pkg::SEQ_W-1:0]       req_seq_num,
   input  wire logic                            req_checksum_ok,
   input  wire logic [srr_pkg::PAYLOAD_W-1:0]   req_payload_word,
   input  wire srr_pkg::back_status_type        status,
   input  wire logic                            queue_empty,
   input  wire logic [BASE_W-1:0]               window_base,
   input  wire logic [HEAD_W-1:0]               head,
   input  wire logic [WINDOW-1:0]               filled,
   output logic                                 queue_push,
   output srr_pkg::queue_word_type              queue_word,
   output logic                                 set_valid,
   output logic [HEAD_W-1:0]                    set_idx,
   output logic                                 wr_en,
   output logic [HEAD_W-1:0]                    wr_addr,
   output logic [srr_pkg::PAYLOAD_W-1:0]        wr_data
);
   localparam int SUM_W  = ((HEAD_W > BASE_W) ? HEAD_W : BASE_W) + 1;

   logic              ready;
   logic              accept;
   logic [8:0]        seq_red;
   logic [BASE_W-1:0] seq_mod;
   logic [BASE_W:0]   diff;
   logic [BASE_W:0]   diff_wrap;
   logic [BASE_W-1:0] offset;
   logic              in_window;
   logic [SUM_W-1:0]  slot_sum;
   logic [HEAD_W-1:0] slot_idx;
   logic              slot_empty;

   // A new word is taken only when the back end has drained the previous one.
   assign ready     = queue_empty && status.idle;
   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   // Reduce the sequence number into the sequence space and find its window offset.
   always_comb begin
      seq_red = 9'(req_seq_num);
      for (int i = 0; i < 4; i++) begin
         if (seq_red >= 9'(SEQ_SPACE)) begin
            seq_red = seq_red - 9'(SEQ_SPACE);
         end
      end
      seq_mod   = seq_red[BASE_W-1:0];
      diff      = {1'b0, seq_mod} - {1'b0, window_base};
      diff_wrap = diff + (BASE_W+1)'(SEQ_SPACE);
      offset    = diff[BASE_W] ? diff_wrap[BASE_W-1:0] : diff[BASE_W-1:0];
      in_window = 9'(offset) < 9'(WINDOW);
   end

   // Map the window offset onto the circular slot index.
   always_comb begin
      slot_sum = SUM_W'(head) + SUM_W'(offset);
      if (slot_sum >= SUM_W'(WINDOW)) begin
         slot_sum = slot_sum - SUM_W'(WINDOW);
      end
      slot_idx   = slot_sum[HEAD_W-1:0];
      slot_empty = !filled[slot_idx];
   end

   // Good words always queue an acknowledgement; new in-window words are buffered.
   always_comb begin
      queue_push     = accept && req_checksum_ok;
      queue_word.seq = seq_red[srr_pkg::SEQ_W-1:0];
      set_valid      = queue_push && in_window && slot_empty;
      set_idx        = slot_idx;
      wr_en          = set_valid;
      wr_addr        = slot_idx;
      wr_data        = req_payload_word;
   end

endmodule
`default_nettype wire

// ===== rtl/srr_back.sv =====
`default_nettype none
module srr_back #(
   parameter int SEQ_SPACE = 8,
   parameter int WINDOW    = 4,
   localparam int BASE_W   = $clog2(SEQ_SPACE),
   localparam int HEAD_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          queue_empty,
   input  wire srr_pkg::queue_word_type       queue_word,
   output logic                               queue_pop,
   input  wire logic                          set_valid,
   input  wire logic [HEAD_W-1:0]             set_idx,
   output logic [BASE_W-1:0]                  window_base,
   output logic [HEAD_W-1:0]                  head,
   output logic [WINDOW-1:0]                  filled,
   output srr_pkg::back_status_type           status,
   output logic                               rd_en,
   output logic [HEAD_W-1:0]                  rd_addr,
   input  wire logic [srr_pkg::PAYLOAD_W-1:0] rd_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_result_kind,
   output logic [srr_pkg::SEQ_W-1:0]          rsp_result_seq,
   output logic [srr_pkg::PAYLOAD_W-1:0]      rsp_result_payload,
   output logic                               rsp_last_of_run
);
   srr_pkg::back_state_type state_ff, state_in;
   logic [BASE_W-1:0]          base_ff, base_in;
   logic [HEAD_W-1:0]          head_ff, head_in;
   logic [WINDOW-1:0]          filled_ff, filled_in;
   logic [srr_pkg::SEQ_W-1:0]  ack_seq_ff, ack_seq_in;
   logic [srr_pkg::SEQ_W-1:0]  dlv_seq_ff, dlv_seq_in;
   logic                       out_valid_ff, out_valid_in;
   logic                       out_kind_ff, out_kind_in;
   logic [srr_pkg::SEQ_W-1:0]  out_seq_ff, out_seq_in;
   logic [srr_pkg::PAYLOAD_W-1:0] out_payload_ff, out_payload_in;
   logic                       out_last_ff, out_last_in;
   logic                       out_free;
   logic [8:0]                 base_ext;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign base_ext = 9'(base_ff);

   // Sequencer: drain filled slots at the window front, then send the acknowledgement.
   always_comb begin
      state_in       = state_ff;
      base_in        = base_ff;
      head_in        = head_ff;
      filled_in      = filled_ff;
      ack_seq_in     = ack_seq_ff;
      dlv_seq_in     = dlv_seq_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      out_kind_in    = out_kind_ff;
      out_seq_in     = out_seq_ff;
      out_payload_in = out_payload_ff;
      out_last_in    = out_last_ff;
      queue_pop      = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = head_ff;

      if (set_valid) begin
         filled_in[set_idx] = 1'b1;
      end

      case (state_ff)
         srr_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               queue_pop  = 1'b1;
               ack_seq_in = queue_word.seq;
               state_in   = srr_pkg::BK_CHECK;
            end
         end
         srr_pkg::BK_CHECK: begin
            if (filled_ff[head_ff]) begin
               rd_en              = 1'b1;
               filled_in[head_ff] = 1'b0;
               dlv_seq_in         = base_ext[srr_pkg::SEQ_W-1:0];
               head_in  = (head_ff == HEAD_W'(WINDOW - 1)) ? '0 : head_ff + 1'b1;
               base_in  = (base_ff == BASE_W'(SEQ_SPACE - 1)) ? '0 : base_ff + 1'b1;
               state_in = srr_pkg::BK_RDATA;
            end else begin
               state_in = srr_pkg::BK_ACK;
            end
         end
         srr_pkg::BK_RDATA: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_kind_in    = srr_pkg::KIND_DELIVER;
               out_seq_in     = dlv_seq_ff;
               out_payload_in = rd_data;
               out_last_in    = 1'b0;
               state_in       = srr_pkg::BK_CHECK;
            end
         end
         srr_pkg::BK_ACK: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_kind_in    = srr_pkg::KIND_ACK;
               out_seq_in     = ack_seq_ff;
               out_payload_in = '0;
               out_last_in    = 1'b1;
               state_in       = srr_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = srr_pkg::BK_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srr_pkg::BK_IDLE;
         base_ff      <= '0;
         head_ff      <= '0;
         filled_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         head_ff      <= head_in;
         filled_ff    <= filled_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ack_seq_ff     <= ack_seq_in;
      dlv_seq_ff     <= dlv_seq_in;
      out_kind_ff    <= out_kind_in;
      out_seq_ff     <= out_seq_in;
      out_payload_ff <= out_payload_in;
      out_last_ff    <= out_last_in;
   end

   assign window_base        = base_ff;
   assign head               = head_ff;
   assign filled             = filled_ff;
   assign status.idle        = (state_ff == srr_pkg::BK_IDLE);
   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_kind_ff;
   assign rsp_result_seq     = out_seq_ff;
   assign rsp_result_payload = out_payload_ff;
   assign rsp_last_of_run    = out_last_ff;

endmodule
`default_nettype wire

// ===== rtl/selective_repeat_receiver_top.sv =====
`default_nettype none
// Each delivered payload takes a slot check with the buffer RAM read, then the output
// load; accept, dequeue, the closing check and the acknowledgement complete a good word,
// and a result stall holds the output load. A corrupt word is accepted and queues nothing.
// Reset clears the window base, slot-filled bits, the command queue and output valid;
// the payload RAM is not cleared and is read only from filled slots.
module selective_repeat_receiver_top #(
   parameter int SEQ_SPACE = 8,
   parameter int WINDOW    = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [srr_pkg::SEQ_W-1:0]     req_seq_num,
   input  wire logic                          req_checksum_ok,
   input  wire logic [srr_pkg::PAYLOAD_W-1:0] req_payload_word,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_result_kind,
   output logic [srr_pkg::SEQ_W-1:0]          rsp_result_seq,
   output logic [srr_pkg::PAYLOAD_W-1:0]      rsp_result_payload,
   output logic                               rsp_last_of_run
);
   localparam int BASE_W = $clog2(SEQ_SPACE);
   localparam int HEAD_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   srr_pkg::back_status_type   status;
   srr_pkg::queue_word_type    push_word;
   srr_pkg::queue_word_type    pop_word;
   logic                       queue_push, queue_pop, queue_empty, queue_full;
   logic [BASE_W-1:0]          window_base;
   logic [HEAD_W-1:0]          head;
   logic [WINDOW-1:0]          filled;
   logic                       set_valid;
   logic [HEAD_W-1:0]          set_idx;
   logic                       wr_en, rd_en;
   logic [HEAD_W-1:0]          wr_addr, rd_addr;
   logic [srr_pkg::PAYLOAD_W-1:0] wr_data, rd_data;

   // Front end: accepts and classifies arriving words.
   srr_front #(.SEQ_SPACE(SEQ_SPACE), .WINDOW(WINDOW)) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_seq_num      (req_seq_num),
      .req_checksum_ok  (req_checksum_ok),
      .req_payload_word (req_payload_word),
      .status           (status),
      .queue_empty      (queue_empty),
      .window_base      (window_base),
      .head             (head),
      .filled           (filled),
      .queue_push       (queue_push),
      .queue_word       (push_word),
      .set_valid        (set_valid),
      .set_idx          (set_idx),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data)
   );

   // Command queue between the two halves.
   srr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_word (push_word),
      .pop       (queue_pop),
      .pop_word  (pop_word),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // Receive buffer, one entry per window slot.
   srr_ram #(.WIDTH(srr_pkg::PAYLOAD_W), .DEPTH(WINDOW)) u_buffer (
      .clock   (clock),
      .wr_en   (wr_en && !queue_full),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Back end: in-order delivery and acknowledgement.
   srr_back #(.SEQ_SPACE(SEQ_SPACE), .WINDOW(WINDOW)) u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_empty        (queue_empty),
      .queue_word         (pop_word),
      .queue_pop          (queue_pop),
      .set_valid          (set_valid),
      .set_idx            (set_idx),
      .window_base        (window_base),
      .head               (head),
      .filled             (filled),
      .status             (status),
      .rd_en              (rd_en),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_result_seq     (rsp_result_seq),
      .rsp_result_payload (rsp_result_payload),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule
`default_nettype wire

// ===== rtl/srr_checker.sv =====
`default_nettype none
module srr_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic                          rsp_result_kind,
   input wire logic [srr_pkg::SEQ_W-1:0]     rsp_result_seq,
   input wire logic [srr_pkg::PAYLOAD_W-1:0] rsp_result_payload,
   input wire logic                          rsp_last_of_run
);

   // A stalled result word holds its value.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind) &&
            $stable(rsp_result_seq) && $stable(rsp_result_payload) &&
            $stable(rsp_last_of_run);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("stalled result word changed");

   // The acknowledgement, and only it, closes a run.
   property p_last_is_ack;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_last_of_run == (rsp_result_kind == srr_pkg::KIND_ACK));
   endproperty
   a_last_is_ack: assert property (p_last_is_ack) else $error("last flag does not match kind");

   // Acknowledgements carry a zero payload.
   property p_ack_payload;
      @(posedge clock) disable iff (reset)
         rsp_valid && (rsp_result_kind == srr_pkg::KIND_ACK) |-> (rsp_result_payload == '0);
   endproperty
   a_ack_payload: assert property (p_ack_payload) else $error("acknowledgement payload not zero");

   // After a reset cycle no result word is shown and the input is open.
   property p_reset_quiet;
      @(posedge clock) reset |=> !rsp_valid && !req_stall;
   endproperty
   a_reset_quiet: assert property (p_reset_quiet) else $error("block not idle after reset");

endmodule

bind selective_repeat_receiver_top srr_checker u_srr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_result_kind    (rsp_result_kind),
   .rsp_result_seq     (rsp_result_seq),
   .rsp_result_payload (rsp_result_payload),
   .rsp_last_of_run    (rsp_last_of_run)
);
`default_nettype wire
